// ===== design/gcb_pkg.sv =====
package gcb_pkg;

	localparam int GUEST_W = 5;
	localparam int TABLE_W = 3;
	localparam int CMD_W = 2;
	localparam int CFG_DW = 6;
	localparam int CFG_IW = 1;
	localparam int NG_W = 6;
	localparam int NT_W = 4;

	localparam logic [CFG_IW-1:0] REG_NUM_GUESTS = 1'd0;
	localparam logic [CFG_IW-1:0] REG_NUM_TABLES = 1'd1;

	typedef enum logic [CMD_W-1:0] {
		CMD_CLEAR = 2'd0,
		CMD_ADD   = 2'd1,
		CMD_SOLVE = 2'd2
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ADD,
		ST_SCAN,
		ST_BACK,
		ST_OSTART,
		ST_OUT,
		ST_FAIL
	} state_t;

	typedef struct packed {
		logic clear;
		logic place;
		logic remove;
	} member_op_t;

endpackage

// ===== design/gcb_ram.sv =====
module gcb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== design/gcb_member_unit.sv =====
module gcb_member_unit
	import gcb_pkg::*;
#(
	parameter int MAX_GUESTS = 32,
	parameter int MAX_TABLES = 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  member_op_t                    op,
	input  logic [((MAX_TABLES > 1) ? $clog2(MAX_TABLES) : 1)-1:0] sel,
	input  logic [$clog2(MAX_GUESTS)-1:0] node,
	input  logic [MAX_GUESTS-1:0]         row,
	output logic                          none
);

	logic [MAX_GUESTS-1:0] members_q [MAX_TABLES];
	logic [MAX_GUESTS-1:0] bit_node;
	logic [MAX_GUESTS-1:0] operand;
	logic [MAX_GUESTS-1:0] masked;

	// one shared and/zero-test: conflict check while scanning, emptiness after removal
	assign bit_node = {{(MAX_GUESTS-1){1'b0}}, 1'b1} << node;
	assign operand  = op.remove ? ~bit_node : row;
	assign masked   = members_q[sel] & operand;
	assign none     = (masked == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_TABLES; i++) begin
				members_q[i] <= '0;
			end
		end else if (op.clear) begin
			for (int i = 0; i < MAX_TABLES; i++) begin
				members_q[i] <= '0;
			end
		end else if (op.place) begin
			members_q[sel] <= members_q[sel] | bit_node;
		end else if (op.remove) begin
			members_q[sel] <= masked;
		end
	end

endmodule

// ===== design/graph_coloring_backtrack_unit.sv =====
// graph coloring by depth-first backtracking
// input channel (in_valid/in_ready): one beat per command. clear empties the
// conflict matrix, add sets one directed conflict bit by a row read and then
// a row write, solve runs the search.
// the search places nodes from num_guests-1 down to 0; each try of one table
// for one node is one use of the shared membership compare unit, a step back
// to the previous node takes an assignment/row fetch and then a removal.
// total solve time is therefore set by the size of the search tree.
// output channel (out_valid/out_ready): on success one beat per node, node 0
// first, last set on node num_guests-1, one beat per cycle when not stalled;
// on failure a single beat with success 0 and last 1.
// in_ready is high only while the sequencer is idle; a stalled receiver holds
// the output register and the sequencer waits, and once the last beat sits in
// the output register the next command is taken.
// configuration writes (cfg_we) take effect at once; made while idle by user, not checked.
// reset clears the conflict matrix valid bits, the table masks and the
// sequencer; num_guests and num_tables come up as 1.
module graph_coloring_backtrack_unit
	import gcb_pkg::*;
#(
	parameter int MAX_GUESTS = 32,
	parameter int MAX_TABLES = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CFG_IW-1:0]   cfg_index,
	input  logic [CFG_DW-1:0]   cfg_data,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [CMD_W-1:0]    cmd,
	input  logic [GUEST_W-1:0]  guest_a,
	input  logic [GUEST_W-1:0]  guest_b,
	output logic                out_valid,
	input  logic                out_ready,
	output logic                success,
	output logic [GUEST_W-1:0]  guest,
	output logic [TABLE_W-1:0]  table_index,
	output logic                last
);

	localparam int GW = $clog2(MAX_GUESTS);
	localparam int TW = (MAX_TABLES > 1) ? $clog2(MAX_TABLES) : 1;
	localparam logic [GW-1:0] G_ONE = GW'(1);
	localparam logic [TW:0] T_ONE = (TW+1)'(1);

	state_t state_q, state_d;

	logic [NG_W-1:0]       num_guests_q;
	logic [NT_W-1:0]       num_tables_q;
	logic [GW-1:0]         nlast_q, nlast_d, nl_cfg;
	logic [TW-1:0]         tlast_q, tlast_d, tl_cfg;
	logic [GW-1:0]         node_q, node_d;
	logic [TW:0]           t_q, t_d;
	logic [GW-1:0]         idx_q, idx_d;
	logic [GW-1:0]         pa_q, pa_d;
	logic [GW-1:0]         pb_q, pb_d;
	logic [MAX_GUESTS-1:0] cv_q;
	logic                  cv_clear, cv_set;
	logic                  crow_ok_q;
	logic                  back;

	logic                  c_we, c_re;
	logic [GW-1:0]         c_waddr, c_raddr;
	logic [MAX_GUESTS-1:0] c_wdata, c_rdata, row;
	logic                  a_we, a_re;
	logic [GW-1:0]         a_raddr;
	logic [TW-1:0]         a_rdata;

	member_op_t            mop;
	logic [TW-1:0]         msel;
	logic                  none;

	logic                  out_valid_q;
	logic                  success_q, last_q;
	logic [GUEST_W-1:0]    guest_q;
	logic [TABLE_W-1:0]    table_q;
	logic                  load, load_ok, load_last;
	logic [GUEST_W-1:0]    load_guest;
	logic [TABLE_W-1:0]    load_table;
	logic                  slot_free;

	gcb_ram #(.WIDTH(MAX_GUESTS), .DEPTH(MAX_GUESTS)) u_conflict_ram (
		.clk   (clk),
		.we    (c_we),
		.waddr (c_waddr),
		.wdata (c_wdata),
		.re    (c_re),
		.raddr (c_raddr),
		.rdata (c_rdata)
	);

	gcb_ram #(.WIDTH(TW), .DEPTH(MAX_GUESTS)) u_assign_ram (
		.clk   (clk),
		.we    (a_we),
		.waddr (node_q),
		.wdata (t_q[TW-1:0]),
		.re    (a_re),
		.raddr (a_raddr),
		.rdata (a_rdata)
	);

	gcb_member_unit #(.MAX_GUESTS(MAX_GUESTS), .MAX_TABLES(MAX_TABLES)) u_members (
		.clk    (clk),
		.arst_n (arst_n),
		.op     (mop),
		.sel    (msel),
		.node   (node_q),
		.row    (row),
		.none   (none)
	);

	assign row       = crow_ok_q ? c_rdata : '0;
	assign slot_free = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);

	// saturate the configured counts into the supported range
	always_comb begin
		if (num_guests_q == '0) begin
			nl_cfg = '0;
		end else if (int'(num_guests_q) > MAX_GUESTS) begin
			nl_cfg = GW'(MAX_GUESTS - 1);
		end else begin
			nl_cfg = GW'(num_guests_q - NG_W'(1));
		end
		if (num_tables_q == '0) begin
			tl_cfg = '0;
		end else if (int'(num_tables_q) > MAX_TABLES) begin
			tl_cfg = TW'(MAX_TABLES - 1);
		end else begin
			tl_cfg = TW'(num_tables_q - NT_W'(1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_guests_q <= NG_W'(1);
			num_tables_q <= NT_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_NUM_GUESTS: num_guests_q <= cfg_data[NG_W-1:0];
				REG_NUM_TABLES: num_tables_q <= cfg_data[NT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		state_d    = state_q;
		node_d     = node_q;
		t_d        = t_q;
		idx_d      = idx_q;
		nlast_d    = nlast_q;
		tlast_d    = tlast_q;
		pa_d       = pa_q;
		pb_d       = pb_q;
		c_re       = 1'b0;
		c_raddr    = node_q;
		c_we       = 1'b0;
		c_waddr    = pa_q;
		c_wdata    = row | ({{(MAX_GUESTS-1){1'b0}}, 1'b1} << pb_q);
		a_re       = 1'b0;
		a_raddr    = node_q;
		a_we       = 1'b0;
		mop        = '0;
		msel       = t_q[TW-1:0];
		cv_clear   = 1'b0;
		cv_set     = 1'b0;
		back       = 1'b0;
		load       = 1'b0;
		load_ok    = 1'b0;
		load_guest = '0;
		load_table = '0;
		load_last  = 1'b0;

		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					unique case (cmd_t'(cmd))
						CMD_CLEAR: begin
							cv_clear = 1'b1;
						end
						CMD_ADD: begin
							if (int'(guest_a) < MAX_GUESTS && int'(guest_b) < MAX_GUESTS) begin
								pa_d    = GW'(guest_a);
								pb_d    = GW'(guest_b);
								c_re    = 1'b1;
								c_raddr = GW'(guest_a);
								state_d = ST_ADD;
							end
						end
						CMD_SOLVE: begin
							mop.clear = 1'b1;
							nlast_d   = nl_cfg;
							tlast_d   = tl_cfg;
							node_d    = nl_cfg;
							t_d       = '0;
							c_re      = 1'b1;
							c_raddr   = nl_cfg;
							state_d   = ST_SCAN;
						end
						default: ;
					endcase
				end
			end
			ST_ADD: begin
				c_we    = 1'b1;
				cv_set  = 1'b1;
				state_d = ST_IDLE;
			end
			ST_SCAN: begin
				if (t_q > {1'b0, tlast_q}) begin
					back = 1'b1;
				end else if (none) begin
					mop.place = 1'b1;
					a_we      = 1'b1;
					if (node_q == '0) begin
						state_d = ST_OSTART;
					end else begin
						node_d  = node_q - G_ONE;
						c_re    = 1'b1;
						c_raddr = node_q - G_ONE;
						t_d     = '0;
					end
				end else begin
					t_d = t_q + T_ONE;
				end
			end
			ST_BACK: begin
				msel       = a_rdata;
				mop.remove = 1'b1;
				// table left empty: the later tables are empty too and are skipped
				if (none) begin
					back = 1'b1;
				end else begin
					t_d     = {1'b0, a_rdata} + T_ONE;
					state_d = ST_SCAN;
				end
			end
			ST_OSTART: begin
				a_re    = 1'b1;
				a_raddr = '0;
				idx_d   = '0;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (slot_free) begin
					load       = 1'b1;
					load_ok    = 1'b1;
					load_guest = GUEST_W'(idx_q);
					load_table = TABLE_W'(a_rdata);
					load_last  = (idx_q == nlast_q);
					if (idx_q == nlast_q) begin
						state_d = ST_IDLE;
					end else begin
						idx_d   = idx_q + G_ONE;
						a_re    = 1'b1;
						a_raddr = idx_q + G_ONE;
					end
				end
			end
			ST_FAIL: begin
				if (slot_free) begin
					load      = 1'b1;
					load_last = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		// step back to the node placed before this one
		if (back) begin
			if (node_q == nlast_q) begin
				state_d = ST_FAIL;
			end else begin
				node_d  = node_q + G_ONE;
				c_re    = 1'b1;
				c_raddr = node_q + G_ONE;
				a_re    = 1'b1;
				a_raddr = node_q + G_ONE;
				state_d = ST_BACK;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			node_q    <= '0;
			t_q       <= '0;
			idx_q     <= '0;
			nlast_q   <= '0;
			tlast_q   <= '0;
			pa_q      <= '0;
			pb_q      <= '0;
			cv_q      <= '0;
			crow_ok_q <= 1'b0;
		end else begin
			state_q <= state_d;
			node_q  <= node_d;
			t_q     <= t_d;
			idx_q   <= idx_d;
			nlast_q <= nlast_d;
			tlast_q <= tlast_d;
			pa_q    <= pa_d;
			pb_q    <= pb_d;
			if (cv_clear) begin
				cv_q <= '0;
			end else if (cv_set) begin
				cv_q[pa_q] <= 1'b1;
			end
			if (c_re) begin
				crow_ok_q <= cv_q[c_raddr];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			success_q <= load_ok;
			guest_q   <= load_guest;
			table_q   <= load_table;
			last_q    <= load_last;
		end
	end

	assign out_valid   = out_valid_q;
	assign success     = success_q;
	assign guest       = guest_q;
	assign table_index = table_q;
	assign last        = last_q;

endmodule
